// ===== rtl/range_add_range_sum_blocks_assert.svh =====
// assertion macros for the range add / range sum block
`ifndef RANGE_ADD_RANGE_SUM_BLOCKS_ASSERT_SVH
`define RANGE_ADD_RANGE_SUM_BLOCKS_ASSERT_SVH
`ifndef SYNTHESIS
`define RARSB_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rarsb assertion failed");
`define RARSB_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rarsb assertion failed");
`else
`define RARSB_CHECK_NOW(lbl, ante, cons)
`define RARSB_CHECK_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/rarsb_pkg.sv =====
package rarsb_pkg;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int BLOCK_SIZE_DEF   = 32;
  localparam int IDX_W            = 11;
  localparam int DATA_W           = 64;
  localparam logic [IDX_W-1:0] COUNT_RESET = 11'd1024;

  typedef enum logic [0:0] {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOCATE,
    S_FETCH,
    S_OP1,
    S_OP2,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t                      op;
    logic [IDX_W-1:0]         first_index;
    logic [IDX_W-1:0]         last_index;
    logic signed [DATA_W-1:0] amount;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] range_sum;
    logic                     range_error;
  } out_t;

endpackage

// ===== rtl/range_add_range_sum_blocks.sv =====
// Range add / range sum over an array of up to MAX_ELEMENTS signed 64-bit values held in
// BLOCK_SIZE-element blocks, each with a pending-add tag and a running sum. After reset the
// block sweeps its memories to zero with in_ready low; cfg writes are taken at any time.
// An item is then accepted in IDLE, LOCATE walks block by block to the block that holds
// first_index, each step goes through FETCH, OP1 and OP2, and DONE presents the result,
// where a step is one element of a partial block or one whole block. The pace is set by
// one shared 64-bit adder and the registered read of the element, tag and sum memories.
// A rejected range goes straight from acceptance to the result. The block is busy from
// acceptance until the result item is taken.
module range_add_range_sum_blocks #(
  parameter int MAX_ELEMENTS = rarsb_pkg::MAX_ELEMENTS_DEF,
  parameter int BLOCK_SIZE   = rarsb_pkg::BLOCK_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  rarsb_pkg::in_t               in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output rarsb_pkg::out_t              out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rarsb_pkg::IDX_W-1:0]  cfg_data
);

  `include "range_add_range_sum_blocks_assert.svh"

  localparam int NUM_BLOCKS = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int EW = $clog2(MAX_ELEMENTS);
  localparam int BW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int OW = $clog2(BLOCK_SIZE);
  localparam int IW = $clog2(MAX_ELEMENTS + BLOCK_SIZE + 1);
  localparam int DW = rarsb_pkg::DATA_W;

  rarsb_pkg::state_t state_r, state_nxt;
  rarsb_pkg::op_t    op_r, op_nxt;
  rarsb_pkg::out_t   out_r, out_nxt;
  logic [rarsb_pkg::IDX_W-1:0] count_r;
  logic [IW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, base_r, base_nxt, i_r, i_nxt;
  logic [BW-1:0] b_r, b_nxt;
  logic [OW-1:0] o_r, o_nxt;
  logic          whole_r, whole_nxt;
  logic [EW-1:0] clr_r, clr_nxt;
  logic [DW-1:0] amount_r, amount_nxt, amt_bs_r, amt_bs_nxt, total_r, total_nxt;

  logic [31:0]   first32, last32, cnt32;
  logic          bad_range;
  logic [DW-1:0] add_a, add_b, add_sum;
  logic [IW-1:0] step_i;

  logic          elem_we, tag_we, sum_we;
  logic [EW-1:0] elem_waddr;
  logic [BW-1:0] blk_waddr;
  logic [DW-1:0] elem_wdata, blk_wdata;
  logic [DW-1:0] elem_rd, tag_rd, sum_rd;

  rarsb_ram #(.DEPTH(MAX_ELEMENTS), .WIDTH(DW)) u_elem (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_waddr),
    .wdata (elem_wdata),
    .raddr (i_r[EW-1:0]),
    .rdata (elem_rd)
  );

  rarsb_ram #(.DEPTH(NUM_BLOCKS), .WIDTH(DW)) u_tag (
    .clk   (clk),
    .we    (tag_we),
    .waddr (blk_waddr),
    .wdata (blk_wdata),
    .raddr (b_r),
    .rdata (tag_rd)
  );

  rarsb_ram #(.DEPTH(NUM_BLOCKS), .WIDTH(DW)) u_sum (
    .clk   (clk),
    .we    (sum_we),
    .waddr (blk_waddr),
    .wdata (blk_wdata),
    .raddr (b_r),
    .rdata (sum_rd)
  );

  // range check against the count capped at the array size
  always_comb begin
    first32   = 32'(in_data.first_index);
    last32    = 32'(in_data.last_index);
    cnt32     = (32'(count_r) > 32'(MAX_ELEMENTS)) ? 32'(MAX_ELEMENTS) : 32'(count_r);
    bad_range = (first32 == 32'd0) || (first32 > last32) || (last32 > cnt32);
  end

  // shared adder operands
  always_comb begin
    add_a = total_r;
    add_b = '0;
    if (state_r == rarsb_pkg::S_OP1) begin
      if (op_r == rarsb_pkg::OP_ADD) begin
        add_a = whole_r ? tag_rd : elem_rd;
        add_b = amount_r;
      end else begin
        add_a = total_r;
        add_b = whole_r ? sum_rd : elem_rd;
      end
    end else if (state_r == rarsb_pkg::S_OP2) begin
      if (op_r == rarsb_pkg::OP_ADD) begin
        add_a = sum_rd;
        add_b = whole_r ? amt_bs_r : amount_r;
      end else begin
        add_a = total_r;
        add_b = whole_r ? '0 : tag_rd;
      end
    end
  end

  assign add_sum = add_a + add_b;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    out_nxt    = out_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    base_nxt   = base_r;
    i_nxt      = i_r;
    b_nxt      = b_r;
    o_nxt      = o_r;
    whole_nxt  = whole_r;
    clr_nxt    = clr_r;
    amount_nxt = amount_r;
    amt_bs_nxt = amt_bs_r;
    total_nxt  = total_r;
    step_i     = i_r;
    elem_we    = 1'b0;
    tag_we     = 1'b0;
    sum_we     = 1'b0;
    elem_waddr = i_r[EW-1:0];
    blk_waddr  = b_r;
    elem_wdata = add_sum;
    blk_wdata  = add_sum;
    case (state_r)
      rarsb_pkg::S_CLEAR: begin
        elem_we    = 1'b1;
        elem_waddr = clr_r;
        elem_wdata = '0;
        blk_waddr  = BW'(clr_r);
        blk_wdata  = '0;
        tag_we     = 32'(clr_r) < 32'(NUM_BLOCKS);
        sum_we     = 32'(clr_r) < 32'(NUM_BLOCKS);
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == EW'(MAX_ELEMENTS - 1)) begin
          state_nxt = rarsb_pkg::S_IDLE;
        end
      end
      rarsb_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_data.op;
          amount_nxt = in_data.amount;
          amt_bs_nxt = DW'(in_data.amount * DW'(BLOCK_SIZE));
          lo_nxt     = IW'(first32 - 32'd1);
          hi_nxt     = IW'(last32 - 32'd1);
          base_nxt   = '0;
          b_nxt      = '0;
          total_nxt  = '0;
          if (bad_range) begin
            out_nxt.range_sum   = '0;
            out_nxt.range_error = 1'b1;
            state_nxt           = rarsb_pkg::S_DONE;
          end else begin
            state_nxt = rarsb_pkg::S_LOCATE;
          end
        end
      end
      rarsb_pkg::S_LOCATE: begin
        if (base_r + IW'(BLOCK_SIZE) <= lo_r) begin
          base_nxt = base_r + IW'(BLOCK_SIZE);
          b_nxt    = b_r + 1'b1;
        end else begin
          i_nxt     = lo_r;
          o_nxt     = OW'(lo_r - base_r);
          state_nxt = rarsb_pkg::S_FETCH;
        end
      end
      rarsb_pkg::S_FETCH: begin
        whole_nxt = (o_r == '0) && (i_r + IW'(BLOCK_SIZE - 1) <= hi_r);
        state_nxt = rarsb_pkg::S_OP1;
      end
      rarsb_pkg::S_OP1: begin
        if (op_r == rarsb_pkg::OP_ADD) begin
          elem_we = !whole_r;
          tag_we  = whole_r;
        end else begin
          total_nxt = add_sum;
        end
        state_nxt = rarsb_pkg::S_OP2;
      end
      rarsb_pkg::S_OP2: begin
        if (op_r == rarsb_pkg::OP_ADD) begin
          sum_we = 1'b1;
        end else begin
          total_nxt = add_sum;
        end
        if (whole_r) begin
          step_i = i_r + IW'(BLOCK_SIZE);
          b_nxt  = b_r + 1'b1;
        end else begin
          step_i = i_r + 1'b1;
          if (o_r == OW'(BLOCK_SIZE - 1)) begin
            o_nxt = '0;
            b_nxt = b_r + 1'b1;
          end else begin
            o_nxt = o_r + 1'b1;
          end
        end
        i_nxt = step_i;
        if (step_i > hi_r) begin
          out_nxt.range_sum   = (op_r == rarsb_pkg::OP_QUERY) ? add_sum : '0;
          out_nxt.range_error = 1'b0;
          state_nxt           = rarsb_pkg::S_DONE;
        end else begin
          state_nxt = rarsb_pkg::S_FETCH;
        end
      end
      rarsb_pkg::S_DONE: begin
        if (out_ready) begin
          state_nxt = rarsb_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rarsb_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rarsb_pkg::S_CLEAR;
      clr_r   <= '0;
      count_r <= rarsb_pkg::COUNT_RESET;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (cfg_valid) begin
        count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    out_r    <= out_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    base_r   <= base_nxt;
    i_r      <= i_nxt;
    b_r      <= b_nxt;
    o_r      <= o_nxt;
    whole_r  <= whole_nxt;
    amount_r <= amount_nxt;
    amt_bs_r <= amt_bs_nxt;
    total_r  <= total_nxt;
  end

  assign in_ready  = (state_r == rarsb_pkg::S_IDLE);
  assign out_valid = (state_r == rarsb_pkg::S_DONE);
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  `RARSB_CHECK_NOW(a_err_sum_zero, out_valid && out_r.range_error, out_r.range_sum == '0)
  `RARSB_CHECK_NOW(a_add_sum_zero, out_valid && (op_r == rarsb_pkg::OP_ADD), out_r.range_sum == '0)
  `RARSB_CHECK_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

// ===== rtl/rarsb_ram.sv =====
module rarsb_ram #(
  parameter int DEPTH = rarsb_pkg::MAX_ELEMENTS_DEF,
  parameter int WIDTH = rarsb_pkg::DATA_W,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
